// ===== rtl/csslin_pkg.sv =====
package csslin_pkg;

  localparam int GammaTableBitsDef  = 10;
  localparam int AlphaFracDigitsDef = 4;
  localparam int AlphaFracW         = 20;
  localparam int OneQ15             = 32768;
  localparam int Den255             = 255;
  localparam int Den100             = 100;

  typedef enum logic [1:0] {
    KIND_HEX   = 2'd0,
    KIND_FUNC  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ALPHA_ONE  = 2'd0,
    ALPHA_ZERO = 2'd1,
    ALPHA_FRAC = 2'd2
  } alpha_sel_e;

  typedef struct packed {
    logic                  fail;
    logic [2:0][7:0]       num;
    logic [2:0]            pct;
    alpha_sel_e            asel;
    logic [AlphaFracW-1:0] afrac;
    logic [2:0]            adig;
  } job_t;

  typedef logic [15:0] q15_tab_t [256];

  function automatic q15_tab_t build_scale255();
    q15_tab_t t;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i * OneQ15 + Den255 / 2) / Den255;
      t[i] = 16'((v > OneQ15) ? OneQ15 : v);
    end
    return t;
  endfunction

  function automatic q15_tab_t build_scale100();
    q15_tab_t t;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i * OneQ15 + Den100 / 2) / Den100;
      t[i] = 16'((v > OneQ15) ? OneQ15 : v);
    end
    return t;
  endfunction

  localparam q15_tab_t Scale255Tab = build_scale255();
  localparam q15_tab_t Scale100Tab = build_scale100();

  function automatic logic [19:0] pow10(input logic [2:0] d);
    logic [19:0] p;
    unique case (d)
      3'd1: p = 20'd10;
      3'd2: p = 20'd100;
      3'd3: p = 20'd1000;
      3'd4: p = 20'd10000;
      3'd5: p = 20'd100000;
      3'd6: p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

  // Reciprocal of pow10 scaled by 2^35, rounded down, for d of 1 to 6; other d give zero.
  function automatic logic [31:0] recip10(input logic [2:0] d);
    logic [31:0] r;
    unique case (d)
      3'd1: r = 32'd3435973836;
      3'd2: r = 32'd343597383;
      3'd3: r = 32'd34359738;
      3'd4: r = 32'd3435973;
      3'd5: r = 32'd343597;
      3'd6: r = 32'd34359;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/csslin_front.sv =====
module csslin_front #(
  parameter int ALPHA_FRACTION_DIGITS = csslin_pkg::AlphaFracDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  input  logic              full_i,
  output logic              push_o,
  output csslin_pkg::job_t  job_o
);
  import csslin_pkg::*;

  localparam int AfW = $clog2(10 ** ALPHA_FRACTION_DIGITS);

  logic [7:0]       cnt_q, cnt_d;
  logic [3:0]       nib_q [6];
  logic [3:0]       nib_d [6];
  logic             bad_q, bad_d;
  logic [1:0]       rgb_q, rgb_d;
  logic [2:0]       nc_q, nc_d;
  logic             in_q, in_d;
  logic [9:0]       acc_q, acc_d;
  logic [7:0]       chv_q [3];
  logic [7:0]       chv_d [3];
  logic [2:0]       pct_q, pct_d;
  logic [7:0]       aint_q, aint_d;
  logic [AfW-1:0]   afrac_q, afrac_d;
  logic [2:0]       adig_q, adig_d;
  logic             accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && last_i;

  always_comb begin
    logic [3:0]  nib;
    logic        hexok;
    logic        dig;
    logic [3:0]  d;
    logic [13:0] acc_t;
    logic [11:0] ai_t;
    cnt_d   = cnt_q;
    nib_d   = nib_q;
    bad_d   = bad_q;
    rgb_d   = rgb_q;
    nc_d    = nc_q;
    in_d    = in_q;
    acc_d   = acc_q;
    chv_d   = chv_q;
    pct_d   = pct_q;
    aint_d  = aint_q;
    afrac_d = afrac_q;
    adig_d  = adig_q;
    nib     = 4'd0;
    hexok   = 1'b1;
    acc_t   = 14'd0;
    ai_t    = 12'd0;

    if (char_i >= "0" && char_i <= "9") begin
      nib = 4'(char_i - 8'd48);
    end else if (char_i >= "a" && char_i <= "f") begin
      nib = 4'(char_i - 8'd87);
    end else if (char_i >= "A" && char_i <= "F") begin
      nib = 4'(char_i - 8'd55);
    end else begin
      hexok = 1'b0;
    end
    if (!hexok) begin
      bad_d = 1'b1;
    end
    for (int k = 0; k < 6; k++) begin
      if (cnt_q == 8'(k)) begin
        nib_d[k] = nib;
      end
    end
    if (cnt_q != 8'd255) begin
      cnt_d = cnt_q + 8'd1;
    end

    dig = (char_i >= "0" && char_i <= "9");
    d   = dig ? 4'(char_i - 8'd48) : 4'd0;

    if (rgb_q != 2'd3) begin
      if (char_i == "r") begin
        rgb_d = 2'd1;
      end else if (rgb_q == 2'd1 && char_i == "g") begin
        rgb_d = 2'd2;
      end else if (rgb_q == 2'd2 && char_i == "b") begin
        rgb_d = 2'd3;
      end else begin
        rgb_d = 2'd0;
      end
    end

    if (dig) begin
      if (!in_q) begin
        if (nc_q < 3'd3) begin
          nc_d           = nc_q + 3'd1;
          acc_d          = 10'(d);
          chv_d[nc_q[1:0]] = 8'(d);
          in_d           = 1'b1;
        end else if (nc_q == 3'd3) begin
          nc_d   = 3'd4;
          aint_d = 8'(d);
          in_d   = 1'b1;
        end
      end else if (nc_q >= 3'd1 && nc_q <= 3'd3) begin
        acc_t = 14'(acc_q) * 14'd10 + 14'(d);
        acc_d = (acc_t > 14'd1023) ? 10'd1023 : acc_t[9:0];
        chv_d[2'(nc_q - 3'd1)] = (acc_d > 10'd255) ? 8'd255 : acc_d[7:0];
      end else if (nc_q == 3'd4) begin
        ai_t   = 12'(aint_q) * 12'd10 + 12'(d);
        aint_d = (ai_t > 12'd255) ? 8'd255 : ai_t[7:0];
      end else if (nc_q == 3'd5) begin
        if (adig_q < 3'(ALPHA_FRACTION_DIGITS)) begin
          afrac_d = AfW'(32'(afrac_q) * 32'd10 + 32'(d));
          adig_d  = adig_q + 3'd1;
        end
      end
    end else if (char_i == "." && ((nc_q == 3'd4 && in_q) || (nc_q == 3'd3 && !in_q))) begin
      nc_d = 3'd5;
      in_d = 1'b1;
    end else begin
      if (char_i == "%" && nc_q >= 3'd1 && nc_q <= 3'd3) begin
        pct_d[2'(nc_q - 3'd1)] = 1'b1;
      end
      in_d = 1'b0;
    end
  end

  always_comb begin
    job_o       = '0;
    job_o.asel  = ALPHA_ONE;
    job_o.afrac = AlphaFracW'(afrac_d);
    job_o.adig  = adig_d;
    if (kind_i == KIND_HEX) begin
      job_o.fail = bad_d || !(cnt_d == 8'd3 || cnt_d == 8'd6);
      for (int k = 0; k < 3; k++) begin
        job_o.num[k] = (cnt_d == 8'd3) ? {nib_d[k], nib_d[k]}
                                       : {nib_d[2*k], nib_d[2*k+1]};
      end
    end else if (kind_i == KIND_FUNC) begin
      job_o.fail = (rgb_d != 2'd3);
      for (int k = 0; k < 3; k++) begin
        job_o.num[k] = chv_d[k];
      end
      job_o.pct = pct_d;
      if (nc_d >= 3'd4) begin
        if (aint_d != 8'd0) begin
          job_o.asel = ALPHA_ONE;
        end else if (adig_d == 3'd0) begin
          job_o.asel = ALPHA_ZERO;
        end else begin
          job_o.asel = ALPHA_FRAC;
        end
      end
    end else begin
      job_o.fail = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      rgb_q   <= '0;
      nc_q    <= '0;
      in_q    <= 1'b0;
      acc_q   <= '0;
      chv_q   <= '{default: '0};
      pct_q   <= '0;
      aint_q  <= '0;
      afrac_q <= '0;
      adig_q  <= '0;
    end else if (accept) begin
      if (last_i) begin
        cnt_q   <= '0;
        bad_q   <= 1'b0;
        rgb_q   <= '0;
        nc_q    <= '0;
        in_q    <= 1'b0;
        acc_q   <= '0;
        chv_q   <= '{default: '0};
        pct_q   <= '0;
        aint_q  <= '0;
        afrac_q <= '0;
        adig_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        bad_q   <= bad_d;
        rgb_q   <= rgb_d;
        nc_q    <= nc_d;
        in_q    <= in_d;
        acc_q   <= acc_d;
        chv_q   <= chv_d;
        pct_q   <= pct_d;
        aint_q  <= aint_d;
        afrac_q <= afrac_d;
        adig_q  <= adig_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nib_q <= nib_d;
    end
  end

endmodule

// ===== rtl/csslin_fifo.sv =====
module csslin_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csslin_pkg::job_t job_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output csslin_pkg::job_t job_o
);
  import csslin_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

// ===== rtl/csslin_back.sv =====
module csslin_back #(
  parameter int GAMMA_TABLE_BITS = csslin_pkg::GammaTableBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  csslin_pkg::job_t job_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [63:0]      data_o,
  output logic             fail_o
);
  import csslin_pkg::*;

  localparam int LutSize = (1 << GAMMA_TABLE_BITS) + 1;
  localparam int Sh      = 15 - GAMMA_TABLE_BITS;
  localparam int Half    = (1 << Sh) >> 1;
  localparam int Iw      = GAMMA_TABLE_BITS + 1;
  localparam int PrW     = AlphaFracW + 32;
  localparam int Nw      = 37;

  typedef logic [15:0] rom_t [LutSize];

  function automatic rom_t build_rom();
    rom_t   r;
    longint x, lo, hi, mid, a, g, q;
    for (int n = 0; n < LutSize; n++) begin
      x  = longint'(n) << (16 - GAMMA_TABLE_BITS);
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        a   = mid;
        for (int k = 0; k < 4; k++) begin
          a = (a * mid) >> 16;
        end
        if (a <= x) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      g    = (((x * x) >> 16) * lo) >> 16;
      q    = (g + 1) >> 1;
      r[n] = 16'((q > OneQ15) ? OneQ15 : q);
    end
    return r;
  endfunction

  logic                  en;
  logic                  a_vld_q, b_vld_q, c_vld_q;
  logic [15:0]           a_lin_q [3];
  logic [PrW-1:0]        a_prod_q;
  logic [AlphaFracW-1:0] a_frac_q;
  logic [2:0]            a_dig_q, b_dig_q;
  alpha_sel_e            a_sel_q, b_sel_q;
  logic                  a_fail_q, b_fail_q;
  logic [15:0]           b_rom_q [3];
  logic [16:0]           b_q0_q;
  logic [Nw-1:0]         b_qp_q, b_n_q;
  logic [63:0]           c_data_q;
  logic                  c_fail_q;
  logic [16:0]           q0;
  logic [15:0]           alpha;

  assign en      = !c_vld_q || ready_i;
  assign pop_o   = en && avail_i;
  assign valid_o = c_vld_q;
  assign data_o  = c_data_q;
  assign fail_o  = c_fail_q;
  assign q0      = a_prod_q[36:20];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= avail_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_lin_q[k] <= job_i.pct[k] ? Scale100Tab[job_i.num[k]] : Scale255Tab[job_i.num[k]];
      end
      a_prod_q <= PrW'(job_i.afrac) * PrW'(recip10(job_i.adig));
      a_frac_q <= job_i.afrac;
      a_dig_q  <= job_i.adig;
      a_sel_q  <= job_i.asel;
      a_fail_q <= job_i.fail;

      b_q0_q   <= q0;
      b_qp_q   <= Nw'(q0) * Nw'(pow10(a_dig_q));
      b_n_q    <= (Nw'(a_frac_q) << 15) + Nw'(pow10(a_dig_q) >> 1);
      b_dig_q  <= a_dig_q;
      b_sel_q  <= a_sel_q;
      b_fail_q <= a_fail_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_rom
    localparam rom_t GammaRom = build_rom();
    logic [16:0]   idx_full;
    logic [Iw-1:0] idx;
    assign idx_full = (17'(a_lin_q[c]) + 17'(Half)) >> Sh;
    assign idx      = (idx_full >= 17'(LutSize)) ? Iw'(LutSize - 1) : idx_full[Iw-1:0];
    always_ff @(posedge clk_i) begin
      if (en) begin
        b_rom_q[c] <= GammaRom[idx];
      end
    end
  end

  always_comb begin
    logic [Nw-1:0] r;
    logic [Nw-1:0] p;
    logic [16:0]   q;
    p = Nw'(pow10(b_dig_q));
    r = b_n_q - b_qp_q;
    q = b_q0_q;
    if (r >= p) begin
      q = q + 17'd1;
      r = r - p;
    end
    if (r >= p) begin
      q = q + 17'd1;
    end
    unique case (b_sel_q)
      ALPHA_ZERO: alpha = 16'd0;
      ALPHA_FRAC: alpha = (q > 17'(OneQ15)) ? 16'(OneQ15) : q[15:0];
      default:    alpha = 16'(OneQ15);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_fail_q <= b_fail_q;
      if (b_fail_q) begin
        c_data_q <= {16'(OneQ15), 48'd0};
      end else begin
        c_data_q <= {alpha, b_rom_q[2], b_rom_q[1], b_rom_q[0]};
      end
    end
  end

endmodule

// ===== rtl/css_color_text_to_linear_rgba_core.sv =====
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tdata char_code, tuser value_kind, tlast is_last
// m_axis   out  m_axis_tvalid/tready       tdata red,green,blue,alpha, tuser failed
//
// One character is taken per cycle while the front queue has room.
// A color value's result is registered in the queue, then in back stages a, b and c.
// The parser, the two-entry queue and the three-stage back pipeline
// stall independently; a full output register holds the back stages.
// Reset clears parser state and empties the queue and the pipeline.
module css_color_text_to_linear_rgba_core #(
  parameter int GAMMA_TABLE_BITS      = csslin_pkg::GammaTableBitsDef,
  parameter int ALPHA_FRACTION_DIGITS = csslin_pkg::AlphaFracDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code
  input  logic [1:0]  s_axis_tuser_i,   // value_kind
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // red, green, blue, alpha
  output logic [0:0]  m_axis_tuser_o    // failed
);
  import csslin_pkg::*;

  job_t job_in, job_out;
  logic push, full, avail, pop, fail;

  csslin_front #(
    .ALPHA_FRACTION_DIGITS(ALPHA_FRACTION_DIGITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .kind_i  (s_axis_tuser_i),
    .char_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .full_i  (full),
    .push_o  (push),
    .job_o   (job_in)
  );

  csslin_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .job_o   (job_out)
  );

  csslin_back #(
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .job_i   (job_out),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o),
    .fail_o  (fail)
  );

  assign m_axis_tuser_o = fail;

  a_fail_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == {16'd32768, 48'd0})
    else $error("failed result is not opaque black");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[63:48] <= 16'd32768)
    else $error("alpha above one");

  a_rgb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:0] <= 16'd32768 &&
      m_axis_tdata_o[31:16] <= 16'd32768 && m_axis_tdata_o[47:32] <= 16'd32768)
    else $error("color channel above one");

  a_queue_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !s_axis_tready_o)
    else $error("request taken while queue full");

endmodule
